// ===== rtl/core/chht_pkg.sv =====
// Package for the color histogram hash table: sizes, codes and the table entry type.
// No dependencies.
`timescale 1ns / 1ps
package chht_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int COLOR_BITS  = 24;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int COUNT_W     = 32;
    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(4079);
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                  used;
        logic [COLOR_BITS-1:0] color;
        logic [COUNT_W-1:0]    count;
    } entry_t;
endpackage

// ===== rtl/core/color_histogram_hash_table.sv =====
// Color histogram in a single-port-write, registered-read hash table memory.
// Add: modulo by the effective length, then a read and a check state per probe, then an output state.
// Query: a scan of every slot below the effective length, then an output state; one item at a time.
// Reset: asynchronous, active low; a clearing pass over all 4096 slots follows,
// one slot a cycle, during which no beat is accepted (config writes still are).
`timescale 1ns / 1ps
module color_histogram_hash_table
    import chht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [COLOR_BITS-1:0] pixel_color,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      slot_index,
    output logic [COUNT_W-1:0]    pixel_count,
    output logic [LEN_W-1:0]      distinct_colors,
    output logic [COLOR_BITS-1:0] rarest_color,
    output logic                  table_empty,
    output logic                  table_full
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_TAIL = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;
    localparam int MCNT_W = $clog2(COLOR_BITS);

    logic [2:0]            state_reg, state_next;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_eff;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pidx_reg;
    logic                  sv_reg, sv_next;
    logic [LEN_W-1:0]      probes_reg, probes_next;
    logic [LEN_W-1:0]      used_reg, used_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic [COLOR_BITS-1:0] div_reg, div_next;
    logic [MCNT_W-1:0]     mcnt_reg, mcnt_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [LEN_W-1:0]      trial;
    // result being built
    logic [IDX_W-1:0]      r_idx_reg, r_idx_next;
    logic [COUNT_W-1:0]    r_cnt_reg, r_cnt_next;
    logic [COLOR_BITS-1:0] r_col_reg, r_col_next;
    logic                  r_found_reg, r_found_next;
    logic                  r_full_reg, r_full_next;
    logic                  r_add_reg, r_add_next;
    logic                  out_valid_reg;

    entry_t                mem [TABLE_DEPTH];
    entry_t                rdata_reg;
    logic                  we;
    entry_t                wdata;
    logic [LEN_W-1:0]      idx_inc;
    logic                  take_scan;

    assign len_eff = (len_reg == '0) ? LEN_W'(1) : ((len_reg > LEN_MAX) ? LEN_MAX : len_reg);
    assign pready  = 1'b1;
    assign prdata  = {{(32-LEN_W){1'b0}}, len_reg};
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign idx_inc   = {1'b0, idx_reg} + LEN_W'(1);
    assign trial     = {rem_reg, div_reg[COLOR_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= LEN_RESET;
        else if (psel && penable && pwrite && !paddr[2])
            len_reg <= pwdata[LEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[idx_reg] <= wdata;
        rdata_reg <= mem[idx_reg];
    end

    assign take_scan = sv_reg && rdata_reg.used &&
                       (!r_found_reg || rdata_reg.count < r_cnt_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sv_next      = 1'b0;
        probes_next  = probes_reg;
        used_next    = used_reg;
        color_next   = color_reg;
        div_next     = div_reg;
        mcnt_next    = mcnt_reg;
        rem_next     = rem_reg;
        r_idx_next   = r_idx_reg;
        r_cnt_next   = r_cnt_reg;
        r_col_next   = r_col_reg;
        r_found_next = r_found_reg;
        r_full_next  = r_full_reg;
        r_add_next   = r_add_reg;
        we           = 1'b0;
        wdata        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    color_next   = pixel_color;
                    div_next     = pixel_color;
                    rem_next     = '0;
                    mcnt_next    = '0;
                    probes_next  = '0;
                    r_idx_next   = '0;
                    r_cnt_next   = '0;
                    r_col_next   = '0;
                    r_found_next = 1'b0;
                    r_full_next  = 1'b0;
                    r_add_next   = (action == ACT_ADD);
                    idx_next     = '0;
                    state_next   = (action == ACT_ADD) ? S_MOD : S_SCAN;
                end
            end
            S_MOD:
            begin
                // restoring division, one dividend bit a cycle
                rem_next  = (trial >= len_eff) ? IDX_W'(trial - len_eff) : trial[IDX_W-1:0];
                div_next  = {div_reg[COLOR_BITS-2:0], 1'b0};
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == MCNT_W'(COLOR_BITS - 1))
                begin
                    idx_next   = (trial >= len_eff) ? IDX_W'(trial - len_eff)
                                                    : trial[IDX_W-1:0];
                    state_next = S_RD;
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (!rdata_reg.used || rdata_reg.color == color_reg)
                begin
                    we          = 1'b1;
                    wdata.used  = 1'b1;
                    wdata.color = color_reg;
                    wdata.count = rdata_reg.used ?
                        ((rdata_reg.count == COUNT_MAX) ? COUNT_MAX
                                                        : rdata_reg.count + COUNT_W'(1))
                        : COUNT_W'(1);
                    if (!rdata_reg.used && used_reg < LEN_MAX)
                        used_next = used_reg + LEN_W'(1);
                    r_idx_next = idx_reg;
                    r_cnt_next = wdata.count;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next    = (idx_inc >= len_eff) ? '0 : idx_inc[IDX_W-1:0];
                    probes_next = probes_reg + LEN_W'(1);
                    if (probes_next == len_eff)
                    begin
                        r_full_next = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                        state_next = S_RD;
                end
            end
            S_SCAN, S_TAIL:
            begin
                if (take_scan)
                begin
                    r_found_next = 1'b1;
                    r_idx_next   = pidx_reg;
                    r_cnt_next   = rdata_reg.count;
                    r_col_next   = rdata_reg.color;
                end
                if (state_reg == S_TAIL)
                    state_next = S_OUT;
                else
                begin
                    sv_next = 1'b1;
                    if (idx_inc == len_eff)
                        state_next = S_TAIL;
                    else
                        idx_next = idx_inc[IDX_W-1:0];
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            sv_reg        <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sv_reg    <= sv_next;
            used_reg  <= used_next;
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= idx_reg;
        probes_reg  <= probes_next;
        color_reg   <= color_next;
        div_reg     <= div_next;
        mcnt_reg    <= mcnt_next;
        rem_reg     <= rem_next;
        r_idx_reg   <= r_idx_next;
        r_cnt_reg   <= r_cnt_next;
        r_col_reg   <= r_col_next;
        r_found_reg <= r_found_next;
        r_full_reg  <= r_full_next;
        r_add_reg   <= r_add_next;
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            distinct_colors <= used_reg;
            table_full      <= r_add_reg && r_full_reg;
            if (r_add_reg)
            begin
                slot_index   <= r_full_reg ? '0 : r_idx_reg;
                pixel_count  <= r_full_reg ? '0 : r_cnt_reg;
                rarest_color <= '0;
                table_empty  <= (used_reg == '0);
            end
            else
            begin
                slot_index   <= r_found_reg ? r_idx_reg : '0;
                pixel_count  <= r_found_reg ? r_cnt_reg : '0;
                rarest_color <= r_found_reg ? r_col_reg : '0;
                table_empty  <= !r_found_reg;
            end
        end
    end
endmodule

// ===== rtl/core/chht_checker.sv =====
// Port-level checks for the color histogram hash table, bound to color_histogram_hash_table.
// Depends on chht_pkg.
`timescale 1ns / 1ps
module chht_port_checks
    import chht_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [IDX_W-1:0]      slot_index,
    input logic [COUNT_W-1:0]    pixel_count,
    input logic [COLOR_BITS-1:0] rarest_color,
    input logic                  table_empty,
    input logic                  table_full
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_index) && $stable(pixel_count))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> pixel_count == '0 && !table_empty)
        else $error("dropped color reported with a count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_empty |-> rarest_color == '0 && pixel_count == '0)
        else $error("empty table reported a color");
endmodule

bind color_histogram_hash_table chht_port_checks u_chht_port_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .pixel_count  (pixel_count),
    .rarest_color (rarest_color),
    .table_empty  (table_empty),
    .table_full   (table_full)
);

// ===== dv/chht_checker.sv =====
// Checker for the color histogram hash table: watches both channels, predicts each
// result from its own copy of the table, and counts mismatches. Depends on chht_pkg.
`timescale 1ns / 1ps
module chht_checker
    import chht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LEN_W-1:0]      cfg_len,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  action,
    input  logic [COLOR_BITS-1:0] pixel_color,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [IDX_W-1:0]      slot_index,
    input  logic [COUNT_W-1:0]    pixel_count,
    input  logic [LEN_W-1:0]      distinct_colors,
    input  logic [COLOR_BITS-1:0] rarest_color,
    input  logic                  table_empty,
    input  logic                  table_full,
    output int                    errors,
    output int                    pending
);
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [IDX_W-1:0]      slot;
        logic [COUNT_W-1:0]    count;
        logic [LEN_W-1:0]      distinct;
        logic [COLOR_BITS-1:0] rare;
        logic                  empty;
        logic                  full;
    } hist_result_t;

    logic [LEN_W-1:0]      len_reg;
    logic                  used_tab [TABLE_DEPTH];
    logic [COLOR_BITS-1:0] color_tab [TABLE_DEPTH];
    logic [COUNT_W-1:0]    count_tab [TABLE_DEPTH];
    int                    used_total;
    hist_result_t          exp_fifo [EXP_DEPTH];
    int                    wr_count;
    int                    rd_count;

    assign pending = wr_count - rd_count;

    function automatic hist_result_t predict_histogram(logic act, logic [COLOR_BITS-1:0] c);
        hist_result_t r;
        int len;
        int idx;
        int probes;
        bit hit;
        bit found;
        len = (len_reg == 0) ? 1 : ((len_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(len_reg));
        r = '0;
        hit = 0;
        found = 0;
        if (act == ACT_ADD) begin
            idx = int'(c) % len;
            for (probes = 0; probes < len; probes++) begin
                if (!used_tab[idx] || color_tab[idx] == c) begin
                    hit = 1;
                    break;
                end
                idx = (idx + 1 >= len) ? 0 : idx + 1;
            end
            if (hit) begin
                if (!used_tab[idx]) begin
                    used_tab[idx] = 1'b1;
                    color_tab[idx] = c;
                    if (used_total < TABLE_DEPTH)
                        used_total++;
                end
                if (count_tab[idx] != COUNT_MAX)
                    count_tab[idx]++;
                r.slot = IDX_W'(idx);
                r.count = count_tab[idx];
            end
            else
                r.full = 1'b1;
            r.empty = (used_total == 0);
        end
        else begin
            for (int i = 0; i < len; i++) begin
                if (used_tab[i] && (!found || count_tab[i] < r.count)) begin
                    found = 1;
                    r.slot = IDX_W'(i);
                    r.count = count_tab[i];
                    r.rare = color_tab[i];
                end
            end
            r.empty = !found;
        end
        r.distinct = LEN_W'(used_total);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        hist_result_t got;
        hist_result_t exp_r;
        if (!rst_n) begin
            len_reg <= LEN_RESET;
            used_total = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                used_tab[i] = 1'b0;
                color_tab[i] = '0;
                count_tab[i] = '0;
            end
            wr_count = 0;
            rd_count = 0;
            errors <= 0;
        end
        else begin
            if (cfg_we)
                len_reg <= cfg_len;
            if (in_valid && !in_stall) begin
                exp_fifo[wr_count % EXP_DEPTH] = predict_histogram(action, pixel_color);
                wr_count++;
            end
            if (out_valid && !out_stall) begin
                got = '{slot_index, pixel_count, distinct_colors, rarest_color,
                        table_empty, table_full};
                if (wr_count == rd_count) begin
                    $display("%0t: unexpected beat, actual %p", $time, got);
                    errors <= errors + 1;
                end
                else begin
                    exp_r = exp_fifo[rd_count % EXP_DEPTH];
                    rd_count++;
                    if (got != exp_r) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, exp_r, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// Testbench top for color_histogram_hash_table: clock, reset, APB writes, stimulus
// and the verdict. Depends on chht_pkg, the block and chht_checker.
`timescale 1ns / 1ps
module tb;
    import chht_pkg::*;

    localparam logic [2:0] REG_TABLE_LENGTH = 3'd0;
    localparam int         CYCLE_LIMIT      = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_W-1:0]      slot_index;
    logic [COUNT_W-1:0]    pixel_count;
    logic [LEN_W-1:0]      distinct_colors;
    logic [COLOR_BITS-1:0] rarest_color;
    logic                  table_empty;
    logic                  table_full;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    bit                    calm;

    color_histogram_hash_table DUT (.*);

    chht_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(psel && penable && pwrite && pready && paddr == REG_TABLE_LENGTH),
        .cfg_len(pwdata[LEN_W-1:0]),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .pixel_color(pixel_color), .out_valid(out_valid), .out_stall(out_stall),
        .slot_index(slot_index), .pixel_count(pixel_count),
        .distinct_colors(distinct_colors), .rarest_color(rarest_color),
        .table_empty(table_empty), .table_full(table_full),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stalls in bursts, quiet once calm is set
    initial
    begin
        out_stall = 0;
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm && $urandom_range(0, 1)) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_length(int unsigned v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= REG_TABLE_LENGTH; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // valid stays up after the beat; drain_results lowers it, the next call only at random gaps
    task automatic send_pixel(logic act, logic [COLOR_BITS-1:0] c);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        pixel_color <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // mostly repeats from a small palette so slots fill, collide and wrap
    task automatic random_phase(int n, int palette);
        logic [COLOR_BITS-1:0] pal [16];
        foreach (pal[i]) pal[i] = COLOR_BITS'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(ACT_QUERY, COLOR_BITS'($urandom));
            else if ($urandom_range(0, 3) == 0)
                send_pixel(ACT_ADD, COLOR_BITS'($urandom));
            else
                send_pixel(ACT_ADD, pal[$urandom_range(0, palette - 1)]);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; action = ACT_ADD; pixel_color = '0; calm = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // empty table, extremes of color, ties, queries at the reset length
        send_pixel(ACT_QUERY, '0);
        send_pixel(ACT_ADD, '0);
        send_pixel(ACT_ADD, '1);
        send_pixel(ACT_ADD, 24'd4079);
        send_pixel(ACT_ADD, '1);
        send_pixel(ACT_QUERY, '1);
        send_pixel(ACT_ADD, 24'haaaaaa);
        send_pixel(ACT_ADD, 24'h555555);
        send_pixel(ACT_QUERY, '0);
        drain_results();

        // length 0 behaves as 1: table fills after one color, then drops
        write_length(0);
        send_pixel(ACT_ADD, 24'h123456);
        send_pixel(ACT_ADD, 24'h000001);
        send_pixel(ACT_ADD, 24'h123456);
        send_pixel(ACT_QUERY, '0);
        drain_results();

        // tiny table: collisions, wrap, full
        write_length(3);
        for (int i = 0; i < 6; i++) send_pixel(ACT_ADD, 24'(i * 3 + 2));
        send_pixel(ACT_QUERY, '0);
        drain_results();

        // above depth acts as depth; max register value
        write_length(13'h1fff);
        send_pixel(ACT_ADD, 24'hfff);
        send_pixel(ACT_QUERY, '0);
        drain_results();

        write_length(7);
        random_phase(200, 4);
        write_length(4096);
        random_phase(150, 16);
        write_length(1);
        random_phase(50, 2);
        write_length(13);
        random_phase(200, 16);
        write_length(31);
        random_phase(200, 8);
        calm = 1;
        write_length(5);
        random_phase(230, 16);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
